// ===== sv/bounded_deque_with_search_delete_defines.svh =====
// ---------------------------------------------------------------------------
// bounded deque assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ---------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DELETE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DELETE_DEFINES_SVH

// same-cycle implication
`define BDQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bdq_pkg.sv =====
// ---------------------------------------------------------------------------
// bdq_pkg
// sizes, command and status codes, and cell control type of the deque
// ---------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic                     push_front;
        logic                     push_back;
        logic                     pop_front;
        logic                     delete_val;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         count;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== sv/bounded_deque_with_search_delete.sv =====
// ---------------------------------------------------------------------------
// bounded_deque_with_search_delete
// ordered store of up to DEPTH signed values with push, pop, search, delete
// ---------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready) carries a command and a value;
//   output channel (o_out_valid / i_out_ready) carries status, popped value
//   and the count after the command. every command gives one result.
//   each command, search and delete included, completes in the cycle of its
//   transfer: the row of cells compares and shifts in parallel, the first
//   match is found by a found chain rippling from front to back.
//   the result is registered and is visible in the cycle after the input transfer.
//   throughput: one command per cycle while the receiver keeps up.
//   the result register decouples the two sides: a new command is taken
//   whenever the result register is empty or its result leaves this cycle.
//   when the receiver stalls the result holds and input stops after one.
//   reset (synchronous, active low) empties the store and the result
//   register; stored values are not cleared, only the count.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bounded_deque_with_search_delete_defines.svh"

module bounded_deque_with_search_delete
    import bdq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [CMD_W-1:0]         i_command,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [STAT_W-1:0]             o_status,
    output logic signed [DATA_W-1:0]      o_popped_value,
    output logic [COUNT_W-1:0]            o_count
);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    logic [STAT_W-1:0]        r_out_status;
    logic [STAT_W-1:0]        n_status;
    logic signed [DATA_W-1:0] r_out_popped;
    logic signed [DATA_W-1:0] n_popped;
    logic [COUNT_W-1:0]       r_out_count;

    logic                     w_accept;
    logic                     w_empty;
    logic                     w_full;
    logic                     w_found;
    logic signed [DATA_W-1:0] w_tail;
    t_cell_ctl                w_ctl;

    logic signed [DATA_W-1:0] w_data  [DEPTH];
    logic                     w_chain [DEPTH+1];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_chain[0] = 1'b0;
    assign w_found    = w_chain[DEPTH];

    // cell control, gated so refused commands leave the row untouched
    always_comb begin
        w_ctl.push_front = w_accept && (i_command == CMD_PUSH_FRONT) && !w_full;
        w_ctl.push_back  = w_accept && (i_command == CMD_PUSH_BACK) && !w_full;
        w_ctl.pop_front  = w_accept && (i_command == CMD_POP_FRONT) && !w_empty;
        w_ctl.delete_val = w_accept && (i_command == CMD_DELETE);
        w_ctl.value      = i_value;
        w_ctl.count      = r_count;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [DATA_W-1:0] w_left;
            logic signed [DATA_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = i_value;
            end else begin : g_mid
                assign w_left = w_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_right = w_data[g];
            end else begin : g_inner
                assign w_right = w_data[g+1];
            end
            bdq_cell u_cell (
                .i_clk        (i_clk),
                .i_idx        (IDX_W'(g)),
                .i_ctl        (w_ctl),
                .i_left_data  (w_left),
                .i_right_data (w_right),
                .i_found      (w_chain[g]),
                .o_found      (w_chain[g+1]),
                .o_data       (w_data[g])
            );
        end
    endgenerate

    // value at the back of the store
    always_comb begin
        w_tail = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i + 1) == r_count) begin
                w_tail = w_data[i];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_popped = '0;
        case (i_command)
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_popped = w_data[0];
                    n_count  = r_count - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_popped = w_tail;
                    n_count  = r_count - 1'b1;
                end
            end
            CMD_SEARCH: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_found) begin
                    n_status = ST_NOTFOUND;
                end
            end
            CMD_DELETE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_found) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_status <= n_status;
            r_out_popped <= n_popped;
            r_out_count  <= COUNT_W'(n_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_popped_value = r_out_popped;
    assign o_count        = r_out_count;

    `BDQ_ASSERT_IMP(a_count_max, 1'b1, r_count <= CNT_W'(DEPTH), "count above depth")
    `BDQ_ASSERT_NXT(a_clear, w_accept && (i_command == CMD_CLEAR), r_count == '0, "clear kept data")
    `BDQ_ASSERT_NXT(a_push_back, w_accept && (i_command == CMD_PUSH_BACK) && !w_full, (r_count == $past(r_count) + 1'b1) && (w_tail == $past(i_value)), "push back lost")
    `BDQ_ASSERT_NXT(a_pop_front, w_accept && (i_command == CMD_POP_FRONT) && !w_empty, r_out_popped == $past(w_data[0]), "pop front value wrong")

endmodule

`default_nettype wire

// ===== sv/bdq_cell.sv =====
// ---------------------------------------------------------------------------
// bdq_cell
// one storage cell: compares against the search value, shifts with neighbors
// ---------------------------------------------------------------------------
`default_nettype none

module bdq_cell
    import bdq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic [IDX_W-1:0]         i_idx,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic signed [DATA_W-1:0] i_left_data,
    input  wire logic signed [DATA_W-1:0] i_right_data,
    input  wire logic                     i_found,
    output logic                          o_found,
    output logic signed [DATA_W-1:0]      o_data
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     w_occ;
    logic                     w_match;
    logic                     w_we;

    assign w_occ   = CNT_W'(i_idx) < i_ctl.count;
    assign w_match = w_occ && (r_data == i_ctl.value);
    assign o_found = i_found | w_match;
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        w_we   = 1'b0;
        if (i_ctl.push_front) begin
            n_data = i_left_data;
            w_we   = 1'b1;
        end else if (i_ctl.push_back && (CNT_W'(i_idx) == i_ctl.count)) begin
            n_data = i_ctl.value;
            w_we   = 1'b1;
        end else if (i_ctl.pop_front || (i_ctl.delete_val && o_found)) begin
            n_data = i_right_data;
            w_we   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire
